// File: rtl/clm_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// clm_pkg
// Types and constants shared by the CPU load monitor.
// ---------------------------------------------------------------------------
package clm_pkg;

  // Request codes carried in item_t.req_type
  typedef enum logic [1:0] {
    REQ_ACTIVE = 2'd0,
    REQ_IDLE   = 2'd1,
    REQ_TICK   = 2'd2,
    REQ_STATUS = 2'd3
  } req_e;

  // Configuration register indexes
  localparam logic [2:0] REG_CPU_COUNT  = 3'd0;
  localparam logic [2:0] REG_INTERVAL   = 3'd1;
  localparam logic [2:0] REG_TICK_RATE  = 3'd2;
  localparam logic [2:0] REG_POLL_TICKS = 3'd3;
  localparam logic [2:0] REG_REFRESH    = 3'd4;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Register reset values
  localparam logic [3:0]  RST_CPU_COUNT  = 4'd1;
  localparam logic [15:0] RST_INTERVAL   = 16'd10;
  localparam logic [15:0] RST_TICK_RATE  = 16'd100;
  localparam logic        RST_POLL_TICKS = 1'b0;
  localparam logic [9:0]  RST_REFRESH    = 10'd500;

  localparam logic [6:0]  PCT_FULL = 7'd100;
  localparam logic [31:0] WIN_SAT  = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [1:0] req_type;
    logic [3:0] cpu_index;
  } item_t;

  typedef struct packed {
    logic [63:0] tick_total;
    logic [63:0] seconds_total;
    logic [6:0]  busy_percent_out;
    logic        percent_updated;
    logic        refresh_pulse;
  } result_t;

  // One per-CPU entry of the window memory
  typedef struct packed {
    logic [6:0]  busy;
    logic [31:0] total;
    logic [31:0] idle;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MOD,
    S_CHK,
    S_SRD,
    S_SMUL,
    S_SDIV,
    S_SWR,
    S_FIN,
    S_FRD,
    S_SECDIV
  } state_e;

endpackage
`default_nettype wire

// File: rtl/cpu_load_monitor_core.sv
`default_nettype none
// ---------------------------------------------------------------------------
// cpu_load_monitor_core
// Per-CPU busy-percent monitor driven by poll, tick and status events.
// ---------------------------------------------------------------------------
// An event is taken when start_i is high and busy_o is low; its result is on
// result_o for one cycle with done_o, and the receiver cannot stall it. An
// event that does not recalculate passes through S_MOD and S_CHK; its result
// strobe is high in the cycle in which the next event may already be taken. A
// tick that recalculates makes one pass per active CPU through the window
// memory (read, multiply, seven-step divide, write back). Writing the tick
// rate keeps busy_o high for a set-up step and a 64-step bit-serial division
// of the tick count to re-derive seconds (no division if the rate is zero).
// Window entries are cleared at reset by per-entry valid bits, so there is
// no clearing pass.
module cpu_load_monitor_core #(
  parameter int unsigned CPU_SLOTS = 8
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               start_i,
  input  clm_pkg::item_t                    item_i,
  output logic                              busy_o,
  output logic                              done_o,
  output clm_pkg::result_t                  result_o,
  input  wire                               cfg_we_i,
  input  wire [clm_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire [clm_pkg::CFG_DATA_W-1:0]     cfg_wdata_i
);

  localparam int unsigned SLOT_W = (CPU_SLOTS > 1) ? $clog2(CPU_SLOTS) : 1;
  localparam int unsigned CNT_W  = $clog2(CPU_SLOTS + 1);
  localparam logic [4:0]  SLOTS5 = 5'(CPU_SLOTS);

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    sat_inc = (v == clm_pkg::WIN_SAT) ? v : v + 32'd1;
  endfunction

  // configuration
  logic [3:0]  cpu_count_q;
  logic [15:0] interval_q;
  logic [15:0] rate_q;
  logic        poll_tick_q;
  logic [9:0]  period_q;
  logic        rate_wr;

  assign rate_wr = cfg_we_i && (cfg_idx_i == clm_pkg::REG_TICK_RATE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cpu_count_q <= clm_pkg::RST_CPU_COUNT;
      interval_q  <= clm_pkg::RST_INTERVAL;
      rate_q      <= clm_pkg::RST_TICK_RATE;
      poll_tick_q <= clm_pkg::RST_POLL_TICKS;
      period_q    <= clm_pkg::RST_REFRESH;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        clm_pkg::REG_CPU_COUNT:  cpu_count_q <= cfg_wdata_i[3:0];
        clm_pkg::REG_INTERVAL:   interval_q  <= cfg_wdata_i;
        clm_pkg::REG_TICK_RATE:  rate_q      <= cfg_wdata_i;
        clm_pkg::REG_POLL_TICKS: poll_tick_q <= cfg_wdata_i[0];
        clm_pkg::REG_REFRESH:    period_q    <= cfg_wdata_i[9:0];
        default: ;
      endcase
    end
  end

  // window memory
  clm_pkg::entry_t mem_q [CPU_SLOTS];
  clm_pkg::entry_t mem_rd_q;
  clm_pkg::entry_t mem_wdata;
  clm_pkg::entry_t rd_entry;
  logic              mem_we, mem_re;
  logic [SLOT_W-1:0] mem_waddr, mem_raddr;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rd_q <= mem_q[mem_raddr];
    end
  end

  // control state
  clm_pkg::state_e   state_q, state_d;
  logic [63:0]       tick_q, tick_d;
  logic [63:0]       last_q, last_d;
  logic [63:0]       sec_q, sec_d;
  logic [15:0]       rem_q, rem_d;
  logic [9:0]        refresh_q, refresh_d;
  logic [CPU_SLOTS-1:0] valid_q, valid_d;
  logic              rd_valid_q, rd_valid_d;
  logic              done_q, done_d;
  logic              div_pend_q, div_pend_d;
  logic              tick_flag_q, tick_flag_d;
  logic [CNT_W-1:0]  idx_q, idx_d;
  logic [2:0]        k_q, k_d;
  logic [5:0]        div_cnt_q, div_cnt_d;

  // payload
  logic [1:0]        req_q, req_d;
  logic [3:0]        cpu_q, cpu_d;
  logic              pulse_q, pulse_d;
  logic [6:0]        hold_busy_q, hold_busy_d;
  logic [38:0]       drem_q, drem_d;
  logic [31:0]       dvs_q, dvs_d;
  logic [6:0]        quo_q, quo_d;
  logic [63:0]       num_q, num_d;
  clm_pkg::result_t  res_q, res_d;

  // combinational helpers
  logic              in_range;
  logic [4:0]        n5;
  logic [CNT_W-1:0]  n_act;
  logic [CNT_W-1:0]  idx_inc;
  logic [63:0]       since;
  logic [38:0]       dsh;
  logic              q_bit;
  logic [6:0]        pct;
  logic [9:0]        refresh_inc;
  logic [16:0]       sd_rem;
  logic              sd_ge;
  logic [16:0]       rem_inc;

  assign in_range = {1'b0, cpu_q} < SLOTS5;
  assign n5       = ({1'b0, cpu_count_q} > SLOTS5) ? SLOTS5 : {1'b0, cpu_count_q};
  assign n_act    = n5[CNT_W-1:0];
  assign idx_inc  = idx_q + CNT_W'(1);
  assign since    = tick_q - last_q;
  assign dsh      = {7'd0, dvs_q} << k_q;
  assign q_bit    = drem_q >= dsh;
  assign pct      = (quo_q > clm_pkg::PCT_FULL) ? clm_pkg::PCT_FULL : quo_q;
  assign refresh_inc = refresh_q + 10'd1;
  assign sd_rem   = {rem_q, num_q[63]};
  assign sd_ge    = sd_rem >= {1'b0, rate_q};
  assign rem_inc  = {1'b0, rem_q} + 17'd1;
  assign rd_entry = rd_valid_q ? mem_rd_q : '0;

  always_comb begin
    state_d     = state_q;
    tick_d      = tick_q;
    last_d      = last_q;
    sec_d       = sec_q;
    rem_d       = rem_q;
    refresh_d   = refresh_q;
    valid_d     = valid_q;
    rd_valid_d  = rd_valid_q;
    done_d      = 1'b0;
    div_pend_d  = div_pend_q | rate_wr;
    tick_flag_d = tick_flag_q;
    idx_d       = idx_q;
    k_d         = k_q;
    div_cnt_d   = div_cnt_q;
    req_d       = req_q;
    cpu_d       = cpu_q;
    pulse_d     = pulse_q;
    hold_busy_d = hold_busy_q;
    drem_d      = drem_q;
    dvs_d       = dvs_q;
    quo_d       = quo_q;
    num_d       = num_q;
    res_d       = res_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_waddr   = cpu_q[SLOT_W-1:0];
    mem_raddr   = cpu_q[SLOT_W-1:0];
    mem_wdata   = rd_entry;

    case (state_q)
      clm_pkg::S_IDLE: begin
        if (div_pend_q) begin
          div_pend_d = rate_wr;
          sec_d      = '0;
          rem_d      = '0;
          num_d      = tick_q;
          div_cnt_d  = '0;
          if (rate_q != 16'd0) begin
            state_d = clm_pkg::S_SECDIV;
          end
        end else if (start_i) begin
          req_d       = item_i.req_type;
          cpu_d       = item_i.cpu_index;
          mem_re      = 1'b1;
          mem_raddr   = item_i.cpu_index[SLOT_W-1:0];
          rd_valid_d  = valid_q[item_i.cpu_index[SLOT_W-1:0]];
          tick_flag_d = (item_i.req_type == clm_pkg::REQ_TICK) ||
                        ((item_i.req_type == clm_pkg::REQ_ACTIVE) &&
                         (item_i.cpu_index == 4'd0) && poll_tick_q);
          state_d     = clm_pkg::S_MOD;
        end
      end

      clm_pkg::S_MOD: begin
        hold_busy_d = in_range ? rd_entry.busy : 7'd0;
        mem_wdata   = rd_entry;
        if (in_range && (req_q == clm_pkg::REQ_ACTIVE || req_q == clm_pkg::REQ_IDLE)) begin
          mem_we          = 1'b1;
          valid_d[cpu_q[SLOT_W-1:0]] = 1'b1;
          mem_wdata.total = sat_inc(rd_entry.total);
          if (req_q == clm_pkg::REQ_IDLE) begin
            mem_wdata.idle = sat_inc(rd_entry.idle);
          end
        end
        if (tick_flag_q) begin
          tick_d = tick_q + 64'd1;
          // seconds and remainder follow the tick count incrementally
          if (tick_q == '1 || rate_q == 16'd0) begin
            sec_d = '0;
            rem_d = '0;
          end else if (rem_inc == {1'b0, rate_q}) begin
            sec_d = sec_q + 64'd1;
            rem_d = '0;
          end else begin
            rem_d = rem_inc[15:0];
          end
        end
        pulse_d = 1'b0;
        if (req_q == clm_pkg::REQ_ACTIVE) begin
          if (refresh_inc >= period_q) begin
            refresh_d = '0;
            pulse_d   = 1'b1;
          end else begin
            refresh_d = refresh_inc;
          end
        end
        state_d = clm_pkg::S_CHK;
      end

      clm_pkg::S_CHK: begin
        if (tick_flag_q && (since >= {48'd0, interval_q})) begin
          last_d  = tick_q;
          idx_d   = '0;
          state_d = (n_act == '0) ? clm_pkg::S_FIN : clm_pkg::S_SRD;
        end else begin
          res_d.tick_total       = tick_q;
          res_d.seconds_total    = sec_q;
          res_d.busy_percent_out = hold_busy_q;
          res_d.percent_updated  = 1'b0;
          res_d.refresh_pulse    = pulse_q;
          done_d                 = 1'b1;
          state_d                = clm_pkg::S_IDLE;
        end
      end

      clm_pkg::S_SRD: begin
        mem_re     = 1'b1;
        mem_raddr  = idx_q[SLOT_W-1:0];
        rd_valid_d = valid_q[idx_q[SLOT_W-1:0]];
        state_d    = clm_pkg::S_SMUL;
      end

      clm_pkg::S_SMUL: begin
        drem_d  = 39'(rd_entry.idle) * 39'(clm_pkg::PCT_FULL);
        dvs_d   = rd_entry.total;
        quo_d   = '0;
        k_d     = 3'd6;
        state_d = clm_pkg::S_SDIV;
      end

      clm_pkg::S_SDIV: begin
        // idle never exceeds total, so the quotient fits in seven bits
        if (q_bit) begin
          drem_d = drem_q - dsh;
        end
        quo_d = {quo_q[5:0], q_bit};
        if (k_q == 3'd0) begin
          state_d = clm_pkg::S_SWR;
        end else begin
          k_d = k_q - 3'd1;
        end
      end

      clm_pkg::S_SWR: begin
        mem_we         = 1'b1;
        mem_waddr      = idx_q[SLOT_W-1:0];
        mem_wdata      = '0;
        mem_wdata.busy = (dvs_q == 32'd0) ? 7'd0 : clm_pkg::PCT_FULL - pct;
        valid_d[idx_q[SLOT_W-1:0]] = 1'b1;
        idx_d          = idx_inc;
        state_d        = (idx_inc == n_act) ? clm_pkg::S_FIN : clm_pkg::S_SRD;
      end

      clm_pkg::S_FIN: begin
        mem_re     = 1'b1;
        rd_valid_d = valid_q[cpu_q[SLOT_W-1:0]];
        state_d    = clm_pkg::S_FRD;
      end

      clm_pkg::S_FRD: begin
        res_d.tick_total       = tick_q;
        res_d.seconds_total    = sec_q;
        res_d.busy_percent_out = in_range ? rd_entry.busy : 7'd0;
        res_d.percent_updated  = 1'b1;
        res_d.refresh_pulse    = pulse_q;
        done_d                 = 1'b1;
        state_d                = clm_pkg::S_IDLE;
      end

      clm_pkg::S_SECDIV: begin
        rem_d     = sd_ge ? 16'(sd_rem - {1'b0, rate_q}) : sd_rem[15:0];
        sec_d     = {sec_q[62:0], sd_ge};
        num_d     = {num_q[62:0], 1'b0};
        div_cnt_d = div_cnt_q + 6'd1;
        if (div_cnt_q == '1) begin
          state_d = clm_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = clm_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= clm_pkg::S_IDLE;
      tick_q      <= '0;
      last_q      <= '0;
      sec_q       <= '0;
      rem_q       <= '0;
      refresh_q   <= '0;
      valid_q     <= '0;
      rd_valid_q  <= 1'b0;
      done_q      <= 1'b0;
      div_pend_q  <= 1'b0;
      tick_flag_q <= 1'b0;
      idx_q       <= '0;
      k_q         <= '0;
      div_cnt_q   <= '0;
    end else begin
      state_q     <= state_d;
      tick_q      <= tick_d;
      last_q      <= last_d;
      sec_q       <= sec_d;
      rem_q       <= rem_d;
      refresh_q   <= refresh_d;
      valid_q     <= valid_d;
      rd_valid_q  <= rd_valid_d;
      done_q      <= done_d;
      div_pend_q  <= div_pend_d;
      tick_flag_q <= tick_flag_d;
      idx_q       <= idx_d;
      k_q         <= k_d;
      div_cnt_q   <= div_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q       <= req_d;
    cpu_q       <= cpu_d;
    pulse_q     <= pulse_d;
    hold_busy_q <= hold_busy_d;
    drem_q      <= drem_d;
    dvs_q       <= dvs_d;
    quo_q       <= quo_d;
    num_q       <= num_d;
    res_q       <= res_d;
  end

  assign busy_o   = (state_q != clm_pkg::S_IDLE) || div_pend_q;
  assign done_o   = done_q;
  assign result_o = res_q;

  // a plain poll or status transaction delivers right after the check
  a_chk_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == clm_pkg::S_CHK && !tick_flag_q) |=> done_q)
    else $error("result strobe missing after window check");

  a_pct_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (res_q.busy_percent_out <= clm_pkg::PCT_FULL))
    else $error("busy percent above full scale");

  a_win_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == clm_pkg::S_SMUL) |-> (rd_entry.idle <= rd_entry.total))
    else $error("idle window count exceeds total");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == clm_pkg::S_IDLE && !div_pend_q && rate_q != 16'd0) |-> (rem_q < rate_q))
    else $error("seconds remainder not below tick rate");

endmodule
`default_nettype wire

// File: test/cpu_load_monitor_core_tb.sv
// ---------------------------------------------------------------------------
// cpu_load_monitor_core_tb
// Self-checking bench for the CPU load monitor core. A driver feeds event
// transactions from a queue, and a monitor predicts each result from a
// behavioural copy of the tick, window and refresh state. It then checks
// every result strobe field by field. The bench steps through several
// register settings, the extremes among them.
// ---------------------------------------------------------------------------
module cpu_load_monitor_core_tb;

  localparam int unsigned SLOTS = 8;
  localparam int unsigned PHASES = 12;
  localparam int unsigned EVENTS_PER_PHASE = 140;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam logic [2:0] REG_FIRST_UNUSED = 3'd5;
  localparam logic [63:0] PCT_MAX = 64'd100;

  typedef struct {
    clm_pkg::item_t item;
    int unsigned    gap;
  } pend_t;

  logic clk_i;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  clm_pkg::item_t item_i = '0;
  logic busy_o;
  logic done_o;
  clm_pkg::result_t result_o;
  logic cfg_we_i = 1'b0;
  logic [clm_pkg::CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [clm_pkg::CFG_DATA_W-1:0] cfg_wdata_i = '0;

  cpu_load_monitor_core #(
    .CPU_SLOTS(SLOTS)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .item_i     (item_i),
    .busy_o     (busy_o),
    .done_o     (done_o),
    .result_o   (result_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  // Predicted register values
  logic [3:0]  cfg_cpu_count  = clm_pkg::RST_CPU_COUNT;
  logic [15:0] cfg_interval   = clm_pkg::RST_INTERVAL;
  logic [15:0] cfg_tick_rate  = clm_pkg::RST_TICK_RATE;
  logic        cfg_poll_ticks = clm_pkg::RST_POLL_TICKS;
  logic [9:0]  cfg_refresh    = clm_pkg::RST_REFRESH;

  // Predicted block state
  logic [63:0] tick_ctr = '0;
  logic [63:0] last_recalc = '0;
  logic [31:0] idle_win [SLOTS];
  logic [31:0] total_win [SLOTS];
  logic [6:0]  busy_pct [SLOTS];
  logic [9:0]  poll_ctr = '0;

  pend_t pending_events[$];
  clm_pkg::result_t due_reports[$];
  pend_t drv_cur;
  bit drv_holding = 1'b0;
  bit item_taken = 1'b0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned idle_bias [SLOTS];

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      idle_win[i] = '0;
      total_win[i] = '0;
      busy_pct[i] = '0;
      idle_bias[i] = 50;
    end
  end

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    return (v == clm_pkg::WIN_SAT) ? v : v + 32'd1;
  endfunction

  // One tick; recalculates every active CPU once the interval has elapsed
  function automatic logic count_tick();
    int unsigned n;
    logic [63:0] ratio;
    tick_ctr = tick_ctr + 64'd1;
    if (tick_ctr - last_recalc < {48'd0, cfg_interval}) return 1'b0;
    n = (cfg_cpu_count > SLOTS) ? SLOTS : cfg_cpu_count;
    for (int i = 0; i < n; i++) begin
      if (total_win[i] != 0) begin
        ratio = ({32'd0, idle_win[i]} * PCT_MAX) / {32'd0, total_win[i]};
        if (ratio > PCT_MAX) ratio = PCT_MAX;
        busy_pct[i] = 7'(PCT_MAX - ratio);
      end else begin
        busy_pct[i] = '0;
      end
      idle_win[i] = '0;
      total_win[i] = '0;
    end
    last_recalc = tick_ctr;
    return 1'b1;
  endfunction

  function automatic clm_pkg::result_t apply_event(input clm_pkg::item_t it);
    clm_pkg::result_t r;
    logic [3:0] cpu;
    logic in_range;
    logic upd;
    logic pulse;
    cpu = it.cpu_index;
    in_range = (cpu < SLOTS);
    upd = 1'b0;
    pulse = 1'b0;
    case (clm_pkg::req_e'(it.req_type))
      clm_pkg::REQ_ACTIVE: begin
        if (in_range) total_win[cpu] = sat_inc(total_win[cpu]);
        if (cpu == 0 && cfg_poll_ticks) upd = count_tick();
        poll_ctr = poll_ctr + 10'd1;
        if (poll_ctr >= cfg_refresh) begin
          poll_ctr = '0;
          pulse = 1'b1;
        end
      end
      clm_pkg::REQ_IDLE: begin
        if (in_range) begin
          idle_win[cpu] = sat_inc(idle_win[cpu]);
          total_win[cpu] = sat_inc(total_win[cpu]);
        end
      end
      clm_pkg::REQ_TICK: upd = count_tick();
      default: ;
    endcase
    r.tick_total = tick_ctr;
    r.seconds_total = (cfg_tick_rate == 0) ? 64'd0 : tick_ctr / {48'd0, cfg_tick_rate};
    r.busy_percent_out = '0;
    if (in_range) r.busy_percent_out = busy_pct[cpu];
    r.percent_updated = upd;
    r.refresh_pulse = pulse;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  task automatic queue_event(input clm_pkg::req_e req, input int unsigned cpu,
                             input int unsigned gap);
    pend_t p;
    p.item.req_type = req;
    p.item.cpu_index = 4'(cpu);
    p.gap = gap;
    pending_events.push_back(p);
  endtask

  task automatic wait_drained();
    while (pending_events.size() != 0 || drv_holding || start_i || due_reports.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Only while idle; tick rate writes keep the block busy for a while
  task automatic cfg_write(input logic [2:0] idx, input logic [15:0] data);
    while (busy_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      clm_pkg::REG_CPU_COUNT:  cfg_cpu_count = data[3:0];
      clm_pkg::REG_INTERVAL:   cfg_interval = data;
      clm_pkg::REG_TICK_RATE:  cfg_tick_rate = data;
      clm_pkg::REG_POLL_TICKS: cfg_poll_ticks = data[0];
      clm_pkg::REG_REFRESH:    cfg_refresh = data[9:0];
      default: ;
    endcase
    repeat (2) @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  task automatic set_config(input logic [15:0] cnt, input logic [15:0] intv,
                            input logic [15:0] rate, input logic [15:0] pt,
                            input logic [15:0] refr);
    cfg_write(clm_pkg::REG_CPU_COUNT, cnt);
    cfg_write(clm_pkg::REG_INTERVAL, intv);
    cfg_write(clm_pkg::REG_POLL_TICKS, pt);
    cfg_write(clm_pkg::REG_REFRESH, refr);
    cfg_write(clm_pkg::REG_TICK_RATE, rate);
  endtask

  function automatic pend_t random_event(input int unsigned gap_style);
    pend_t p;
    int unsigned roll;
    int unsigned cpu;
    roll = $urandom_range(0, 99);
    cpu = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 15) : $urandom_range(0, 7);
    if (roll < 15) p.item.req_type = clm_pkg::REQ_TICK;
    else if (roll < 25) p.item.req_type = clm_pkg::REQ_STATUS;
    else if (cpu < SLOTS && $urandom_range(1, 100) <= idle_bias[cpu])
      p.item.req_type = clm_pkg::REQ_IDLE;
    else if (cpu >= SLOTS && $urandom_range(0, 1) == 1) p.item.req_type = clm_pkg::REQ_IDLE;
    else p.item.req_type = clm_pkg::REQ_ACTIVE;
    p.item.cpu_index = 4'(cpu);
    case (gap_style)
      0: p.gap = 0;
      1: p.gap = $urandom_range(0, 13);
      default: p.gap = ($urandom_range(0, 9) < 7) ? 0 : $urandom_range(0, 13);
    endcase
    return p;
  endfunction

  // Driver: one transaction per accepted start, optional idle cycles before each
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!start_i || item_taken) begin
        item_taken = 1'b0;
        if (!drv_holding && pending_events.size() != 0) begin
          drv_cur = pending_events.pop_front();
          drv_holding = 1'b1;
        end
        if (drv_holding && drv_cur.gap == 0) begin
          item_i <= drv_cur.item;
          start_i <= 1'b1;
          drv_holding = 1'b0;
        end else begin
          start_i <= 1'b0;
          if (drv_holding) drv_cur.gap--;
        end
      end
    end
  end

  // Monitor: check strobed results first, then predict the accepted event
  always @(posedge clk_i) begin
    clm_pkg::result_t want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Simulation FAILED");
      $finish;
    end else if (rst_ni) begin
      if (done_o) begin
        if (due_reports.size() == 0) begin
          report_mismatch("result with no transaction pending", result_o.tick_total, '0);
        end else begin
          want = due_reports.pop_front();
          if (result_o.tick_total !== want.tick_total)
            report_mismatch("tick_total", result_o.tick_total, want.tick_total);
          if (result_o.seconds_total !== want.seconds_total)
            report_mismatch("seconds_total", result_o.seconds_total, want.seconds_total);
          if (result_o.busy_percent_out !== want.busy_percent_out)
            report_mismatch("busy_percent_out", 64'(result_o.busy_percent_out),
                            64'(want.busy_percent_out));
          if (result_o.percent_updated !== want.percent_updated)
            report_mismatch("percent_updated", 64'(result_o.percent_updated),
                            64'(want.percent_updated));
          if (result_o.refresh_pulse !== want.refresh_pulse)
            report_mismatch("refresh_pulse", 64'(result_o.refresh_pulse),
                            64'(want.refresh_pulse));
        end
      end
      if (start_i && !busy_o) begin
        item_taken = 1'b1;
        due_reports.push_back(apply_event(item_i));
      end
    end
  end

  initial begin
    int unsigned gap_style;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reads, in-range and out-of-range polls, then a full interval of ticks
    queue_event(clm_pkg::REQ_STATUS, 0, 0);
    queue_event(clm_pkg::REQ_STATUS, 15, 1);
    queue_event(clm_pkg::REQ_ACTIVE, 0, 0);
    queue_event(clm_pkg::REQ_ACTIVE, 0, 0);
    queue_event(clm_pkg::REQ_IDLE, 0, 2);
    queue_event(clm_pkg::REQ_IDLE, 3, 0);
    queue_event(clm_pkg::REQ_ACTIVE, 9, 0);
    queue_event(clm_pkg::REQ_IDLE, 15, 5);
    for (int i = 0; i < 10; i++) queue_event(clm_pkg::REQ_TICK, 0, i % 3);
    queue_event(clm_pkg::REQ_STATUS, 0, 0);
    queue_event(clm_pkg::REQ_STATUS, 3, 0);
    queue_event(clm_pkg::REQ_STATUS, 8, 13);
    wait_drained();

    for (int ph = 1; ph <= PHASES; ph++) begin
      case (ph)
        1: set_config(16'd8, 16'd1, 16'd1, 16'd1, 16'd1);
        2: set_config(16'd15, 16'd0, 16'd0, 16'd0, 16'd0);
        3: set_config(16'd0, 16'd3, 16'hFFFF, 16'd1, 16'd1023);
        4: set_config(16'hFFF8, 16'hFFFF, 16'd3, 16'hFFFF, 16'hFC07);
        default: begin
          set_config(16'($urandom_range(0, 65535)),
                     16'($urandom_range(0, 24)),
                     ($urandom_range(0, 5) == 0) ? 16'd0 : 16'($urandom_range(1, 65535)),
                     16'($urandom_range(0, 65535)),
                     {6'($urandom_range(0, 63)), 10'($urandom_range(0, 40))});
        end
      endcase
      // unused index, must change nothing
      if (ph == 5) cfg_write(REG_FIRST_UNUSED + 3'($urandom_range(0, 2)),
                             16'($urandom_range(0, 65535)));

      for (int c = 0; c < SLOTS; c++) begin
        if ($urandom_range(0, 3) == 0) idle_bias[c] = $urandom_range(0, 1) ? 100 : 0;
        else idle_bias[c] = $urandom_range(0, 100);
      end
      gap_style = (ph == 1) ? 0 : $urandom_range(0, 2);
      for (int k = 0; k < EVENTS_PER_PHASE; k++)
        pending_events.push_back(random_event(gap_style));
      wait_drained();
    end

    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
